@@ src/plcr_pkg.sv @@
// Shared types and constants for the piecewise-linear color ramp.
// Used by plcr_ram users, plcr_div and piecewise_linear_color_ramp.
// No dependencies.
package plcr_pkg;

  localparam int MAX_POINTS    = 32;
  localparam int POSITION_BITS = 10;
  localparam int CHANNELS      = 3;

  localparam int LEVEL_BITS = 8;
  localparam int FRAC_BITS  = 8;
  localparam int HEIGHT     = 255;   // full-scale level
  localparam int COUNT_BITS = 6;
  localparam int CH_BITS    = 2;
  localparam int PIDX_BITS  = 5;     // width of the point_index field
  localparam int OUT_BITS   = 16;
  localparam int COUNT_MIN  = 2;

  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int ENTRY_BITS = POSITION_BITS + LEVEL_BITS;
  localparam int RAM_DEPTH  = CHANNELS * MAX_POINTS;
  localparam int ADDR_BITS  = $clog2(RAM_DEPTH);

  // interpolation numerator: two level*distance products, summed, in Q.8
  localparam int PROD_BITS = LEVEL_BITS + POSITION_BITS;
  localparam int NUM_BITS  = PROD_BITS + 1 + FRAC_BITS;
  localparam int DIV_BITS  = NUM_BITS + (NUM_BITS % 2);
  localparam int DIV_STEPS = DIV_BITS / 2;
  localparam int STEP_BITS = $clog2(DIV_STEPS);
  localparam int REM_BITS  = POSITION_BITS + 1;

  // configuration register indexes
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_COUNT_RED   = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_COUNT_GREEN = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_COUNT_BLUE  = 2'd2;

  // item kinds carried in tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic [POSITION_BITS-1:0] pos;
    logic [LEVEL_BITS-1:0]    lvl;
  } entry_t;

  // input tdata layout, first field (pad) in the high bits, channel in the low bits
  typedef struct packed {
    logic [4:0]                pad;
    logic [POSITION_BITS-1:0]  position;
    logic [LEVEL_BITS-1:0]     point_level;
    logic [POSITION_BITS-1:0]  point_position;
    logic [PIDX_BITS-1:0]      point_index;
    logic [CH_BITS-1:0]        channel;
  } in_data_t;

  localparam int IN_DATA_BITS = $bits(in_data_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD0,
    S_RDL,
    S_CHK,
    S_SCAN,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

endpackage

@@ src/plcr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module plcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/plcr_div.sv @@
// Restoring divider, two quotient bits per cycle.
// Depends on plcr_pkg.
module plcr_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [plcr_pkg::NUM_BITS-1:0]       dividend,
  input  logic [plcr_pkg::POSITION_BITS-1:0]  divisor,
  output logic                                done,
  output logic [plcr_pkg::OUT_BITS-1:0]       quotient
);

  logic                                busy;
  logic [plcr_pkg::STEP_BITS-1:0]      step;
  logic [plcr_pkg::DIV_BITS-1:0]       dvd;
  logic [plcr_pkg::POSITION_BITS-1:0]  dsr;
  logic [plcr_pkg::POSITION_BITS-1:0]  rem;

  logic [plcr_pkg::REM_BITS-1:0]       trial1, trial2;
  logic [plcr_pkg::POSITION_BITS-1:0]  rem1, rem2;
  logic                                qb1, qb2;

  always_comb begin
    trial1 = {rem, dvd[plcr_pkg::DIV_BITS-1]};
    qb1    = trial1 >= {1'b0, dsr};
    rem1   = qb1 ? plcr_pkg::POSITION_BITS'(trial1 - {1'b0, dsr})
                 : plcr_pkg::POSITION_BITS'(trial1);
    trial2 = {rem1, dvd[plcr_pkg::DIV_BITS-2]};
    qb2    = trial2 >= {1'b0, dsr};
    rem2   = qb2 ? plcr_pkg::POSITION_BITS'(trial2 - {1'b0, dsr})
                 : plcr_pkg::POSITION_BITS'(trial2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        done <= 1'b0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == plcr_pkg::STEP_BITS'(plcr_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          done <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= plcr_pkg::DIV_BITS'(dividend);
      dsr      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[plcr_pkg::DIV_BITS-3:0], 2'b00};
      rem      <= rem2;
      // upper quotient bits are known zero, so they drop off the top
      quotient <= {quotient[plcr_pkg::OUT_BITS-3:0], qb1, qb2};
    end
  end

endmodule

@@ src/piecewise_linear_color_ramp.sv @@
// Piecewise-linear color ramp: breakpoint store, segment scan and Q8.8 interpolation.
// Depends on plcr_pkg, plcr_ram and plcr_div.
//
//  channel  | signals                         | payload
//  ---------+---------------------------------+------------------------------------------
//  input    | s_axis_tvalid/tready/tdata/tuser| tuser: op; tdata: channel, point_index,
//           |                                 |   point_position, point_level, position
//  output   | m_axis_tvalid/tready/tdata      | tdata: level (Q8.8)
//  config   | cfg_we/cfg_index/cfg_data       | count_red, count_green, count_blue
//
// A write is taken in the idle state. A query steps through accept, two table reads, range check,
// a scan of 1 to count-1 breakpoints and, when it interpolates, operand load, DIV_STEPS = 14
// divider steps and done, then the result.
// The scan rate is set by the single read port of the breakpoint RAM, one entry a cycle.
// Reset clears control state only and holds off the input; RAM contents are undefined.
// A finished result waits in the output register while the next item is taken.
module piecewise_linear_color_ramp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [plcr_pkg::REG_IDX_BITS-1:0]     cfg_index,
  input  logic [plcr_pkg::COUNT_BITS-1:0]       cfg_data,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // channel, point_index, point_position, point_level, position (zero padded)
  input  logic [plcr_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
  // op
  input  logic [0:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // level
  output logic [plcr_pkg::OUT_BITS-1:0]         m_axis_tdata
);

  plcr_pkg::state_t   state, state_next;
  plcr_pkg::in_data_t din;

  logic [plcr_pkg::COUNT_BITS-1:0]    count_red, count_green, count_blue;
  logic [plcr_pkg::COUNT_BITS-1:0]    count_sel, count_used;

  logic                               in_acc;
  logic                               wr_ok;
  logic [plcr_pkg::CH_BITS-1:0]       ch_q;
  logic [plcr_pkg::POSITION_BITS-1:0] x_q;
  logic [plcr_pkg::IDX_BITS-1:0]      last_q, k_q, rd_idx;
  logic                               ch_bad;

  logic                               ram_we;
  logic [plcr_pkg::ADDR_BITS-1:0]     ram_waddr, ram_raddr;
  plcr_pkg::entry_t                   ram_wdata, rd;

  plcr_pkg::entry_t                   prev_q, cur_q;
  logic [plcr_pkg::OUT_BITS-1:0]      res_q;

  logic                               scan_more, degenerate;
  logic                               out_free;

  logic                               div_start, div_done;
  logic [plcr_pkg::POSITION_BITS-1:0] seg_d, dist_r, dist_l;
  logic [plcr_pkg::PROD_BITS-1:0]     prod_l, prod_r;
  logic [plcr_pkg::NUM_BITS-1:0]      numer;
  logic [plcr_pkg::OUT_BITS-1:0]      quotient;

  assign din      = plcr_pkg::in_data_t'(s_axis_tdata);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign ch_bad   = int'(din.channel) >= plcr_pkg::CHANNELS;
  assign wr_ok    = !ch_bad && (int'(din.point_index) < plcr_pkg::MAX_POINTS);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_red   <= plcr_pkg::COUNT_BITS'(plcr_pkg::COUNT_MIN);
      count_green <= plcr_pkg::COUNT_BITS'(plcr_pkg::COUNT_MIN);
      count_blue  <= plcr_pkg::COUNT_BITS'(plcr_pkg::COUNT_MIN);
    end else if (cfg_we) begin
      case (cfg_index)
        plcr_pkg::REG_COUNT_RED:   count_red   <= cfg_data;
        plcr_pkg::REG_COUNT_GREEN: count_green <= cfg_data;
        plcr_pkg::REG_COUNT_BLUE:  count_blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (din.channel)
      2'd0:    count_sel = count_red;
      2'd1:    count_sel = count_green;
      2'd2:    count_sel = count_blue;
      default: count_sel = count_red;
    endcase
    if (int'(count_sel) < plcr_pkg::COUNT_MIN) begin
      count_used = plcr_pkg::COUNT_BITS'(plcr_pkg::COUNT_MIN);
    end else if (int'(count_sel) > plcr_pkg::MAX_POINTS) begin
      count_used = plcr_pkg::COUNT_BITS'(plcr_pkg::MAX_POINTS);
    end else begin
      count_used = count_sel;
    end
  end

  // breakpoint store
  assign ram_wdata = '{pos: din.point_position, lvl: din.point_level};
  assign ram_waddr = plcr_pkg::ADDR_BITS'(int'(din.channel) * plcr_pkg::MAX_POINTS
                                          + int'(din.point_index));
  assign ram_raddr = plcr_pkg::ADDR_BITS'(int'(ch_q) * plcr_pkg::MAX_POINTS + int'(rd_idx));

  plcr_ram #(
    .WIDTH (plcr_pkg::ENTRY_BITS),
    .DEPTH (plcr_pkg::RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // scan decisions on the entry just read
  assign scan_more  = (k_q < last_q) && (rd.pos < x_q);
  assign degenerate = (rd.pos <= prev_q.pos) || (x_q < prev_q.pos) || (x_q > rd.pos);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plcr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      plcr_pkg::S_IDLE: begin
        if (in_acc && s_axis_tuser[0] == plcr_pkg::OP_QUERY) begin
          state_next = ch_bad ? plcr_pkg::S_DONE : plcr_pkg::S_RD0;
        end
      end
      plcr_pkg::S_RD0: state_next = plcr_pkg::S_RDL;
      plcr_pkg::S_RDL: state_next = plcr_pkg::S_CHK;
      plcr_pkg::S_CHK: begin
        if (x_q <= prev_q.pos || x_q >= rd.pos) begin
          state_next = plcr_pkg::S_DONE;
        end else begin
          state_next = plcr_pkg::S_SCAN;
        end
      end
      plcr_pkg::S_SCAN: begin
        if (!scan_more) begin
          state_next = degenerate ? plcr_pkg::S_DONE : plcr_pkg::S_MUL;
        end
      end
      plcr_pkg::S_MUL: state_next = plcr_pkg::S_DIV;
      plcr_pkg::S_DIV: begin
        if (div_done) begin
          state_next = plcr_pkg::S_DONE;
        end
      end
      plcr_pkg::S_DONE: begin
        if (out_free) begin
          state_next = plcr_pkg::S_IDLE;
        end
      end
      default: state_next = plcr_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    div_start     = 1'b0;
    rd_idx        = '0;
    case (state)
      plcr_pkg::S_IDLE: begin
        s_axis_tready = !rst;
        ram_we        = in_acc && s_axis_tuser[0] == plcr_pkg::OP_WRITE && wr_ok;
      end
      plcr_pkg::S_RD0:  rd_idx = '0;
      plcr_pkg::S_RDL:  rd_idx = last_q;
      plcr_pkg::S_CHK:  rd_idx = plcr_pkg::IDX_BITS'(1);
      // read one entry ahead, never past the last one in use
      plcr_pkg::S_SCAN: rd_idx = (k_q < last_q) ? k_q + 1'b1 : k_q;
      plcr_pkg::S_MUL:  div_start = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      plcr_pkg::S_IDLE: begin
        if (in_acc) begin
          ch_q   <= din.channel;
          x_q    <= din.position;
          last_q <= plcr_pkg::IDX_BITS'(count_used - 1'b1);
          res_q  <= '0;
        end
      end
      plcr_pkg::S_RDL: prev_q <= rd;
      plcr_pkg::S_CHK: begin
        k_q <= plcr_pkg::IDX_BITS'(1);
        if (x_q <= prev_q.pos) begin
          res_q <= {prev_q.lvl, plcr_pkg::FRAC_BITS'(0)};
        end else begin
          res_q <= {rd.lvl, plcr_pkg::FRAC_BITS'(0)};
        end
      end
      plcr_pkg::S_SCAN: begin
        if (scan_more) begin
          prev_q <= rd;
          k_q    <= k_q + 1'b1;
        end else begin
          cur_q <= rd;
          res_q <= {rd.lvl, plcr_pkg::FRAC_BITS'(0)};
        end
      end
      plcr_pkg::S_DIV: begin
        if (div_done) begin
          res_q <= quotient;
        end
      end
      default: ;
    endcase
  end

  // interpolation numerator, rounded to nearest by adding half the segment length
  always_comb begin
    seg_d  = cur_q.pos - prev_q.pos;
    dist_r = cur_q.pos - x_q;
    dist_l = x_q - prev_q.pos;
    prod_l = plcr_pkg::PROD_BITS'(prev_q.lvl) * plcr_pkg::PROD_BITS'(dist_r);
    prod_r = plcr_pkg::PROD_BITS'(cur_q.lvl) * plcr_pkg::PROD_BITS'(dist_l);
    numer  = ((plcr_pkg::NUM_BITS'(prod_l) + plcr_pkg::NUM_BITS'(prod_r))
              << plcr_pkg::FRAC_BITS) + plcr_pkg::NUM_BITS'(seg_d >> 1);
  end

  plcr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (numer),
    .divisor  (seg_d),
    .done     (div_done),
    .quotient (quotient)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == plcr_pkg::S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == plcr_pkg::S_DONE && out_free) begin
      m_axis_tdata <= res_q;
    end
  end

  // checks
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> seg_d != '0)
    else $error("divider started on a zero-length segment");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == plcr_pkg::S_SCAN |-> k_q <= last_q)
    else $error("scan index beyond last breakpoint");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == plcr_pkg::S_DIV)
    else $error("divider finished outside the divide state");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    state == plcr_pkg::S_DONE |->
      res_q <= plcr_pkg::OUT_BITS'(plcr_pkg::HEIGHT << plcr_pkg::FRAC_BITS))
    else $error("level above full scale");

endmodule

@@ verif/tb_piecewise_linear_color_ramp.sv @@
// Self-checking testbench for piecewise_linear_color_ramp: a directed table, then random
// phases of breakpoint ramps and queries, checked against an in-bench Q8.8 interpolator.
// Depends on plcr_pkg and the RTL top level only.
`timescale 1ns / 1ps

module tb_piecewise_linear_color_ramp;
  import plcr_pkg::*;

  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          ITEM_TARGET  = 1450;
  localparam int          DRAIN_CYCLES = 64;
  localparam int          HOLD_CYCLES  = 600;
  localparam int          IDLE_PCT     = 18;

  localparam logic [REG_IDX_BITS-1:0] COUNT_REGS [CHANNELS] =
    '{REG_COUNT_RED, REG_COUNT_GREEN, REG_COUNT_BLUE};

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_COUNT} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [1:0]               sel;     // channel, or register index for ROW_COUNT
    logic [PIDX_BITS-1:0]     idx;
    logic [POSITION_BITS-1:0] ppos;
    logic [LEVEL_BITS-1:0]    plvl;
    logic [POSITION_BITS-1:0] x;
    logic [COUNT_BITS-1:0]    cnt;
    logic                     pinned;  // expected level typed in below
    logic [OUT_BITS-1:0]      pin;
  } dir_row_t;

  typedef struct packed {
    logic                     op;
    logic [CH_BITS-1:0]       ch;
    logic [PIDX_BITS-1:0]     idx;
    logic [POSITION_BITS-1:0] ppos;
    logic [LEVEL_BITS-1:0]    plvl;
    logic [POSITION_BITS-1:0] x;
  } ramp_item_t;

  localparam dir_row_t DIRECTED [24] = '{
    '{ROW_WRITE, 2'd0, 5'd0,  10'd0,    8'd0,   10'd0,    6'd0,  1'b0, 16'h0000},
    '{ROW_WRITE, 2'd0, 5'd1,  10'd1023, 8'd255, 10'd0,    6'd0,  1'b0, 16'h0000},
    '{ROW_QUERY, 2'd0, 5'd0,  10'd0,    8'd0,   10'd0,    6'd0,  1'b1, 16'h0000},
    '{ROW_QUERY, 2'd0, 5'd0,  10'd0,    8'd0,   10'd1023, 6'd0,  1'b1, 16'hFF00},
    '{ROW_QUERY, 2'd0, 5'd0,  10'd0,    8'd0,   10'd512,  6'd0,  1'b0, 16'h0000},
    '{ROW_QUERY, 2'd0, 5'd0,  10'd0,    8'd0,   10'd1,    6'd0,  1'b0, 16'h0000},
    // falling positions
    '{ROW_WRITE, 2'd1, 5'd0,  10'd1023, 8'd255, 10'd0,    6'd0,  1'b0, 16'h0000},
    '{ROW_WRITE, 2'd1, 5'd1,  10'd0,    8'd0,   10'd0,    6'd0,  1'b0, 16'h0000},
    '{ROW_QUERY, 2'd1, 5'd0,  10'd0,    8'd0,   10'd0,    6'd0,  1'b1, 16'hFF00},
    '{ROW_QUERY, 2'd1, 5'd0,  10'd0,    8'd0,   10'd1023, 6'd0,  1'b1, 16'hFF00},
    // zero-length segment
    '{ROW_WRITE, 2'd2, 5'd0,  10'd300,  8'd128, 10'd0,    6'd0,  1'b0, 16'h0000},
    '{ROW_WRITE, 2'd2, 5'd1,  10'd300,  8'd17,  10'd0,    6'd0,  1'b0, 16'h0000},
    '{ROW_QUERY, 2'd2, 5'd0,  10'd0,    8'd0,   10'd300,  6'd0,  1'b1, 16'h8000},
    '{ROW_QUERY, 2'd2, 5'd0,  10'd0,    8'd0,   10'd301,  6'd0,  1'b1, 16'h1100},
    // channel 3: write dropped, query answers zero
    '{ROW_WRITE, 2'd3, 5'd0,  10'd682,  8'd170, 10'd341,  6'd0,  1'b0, 16'h0000},
    '{ROW_QUERY, 2'd3, 5'd0,  10'd0,    8'd0,   10'd1023, 6'd0,  1'b1, 16'h0000},
    '{ROW_WRITE, 2'd1, 5'd31, 10'd682,  8'd85,  10'd0,    6'd0,  1'b0, 16'h0000},
    // counts outside 2..32 are clamped
    '{ROW_COUNT, REG_COUNT_GREEN, 5'd0, 10'd0, 8'd0, 10'd0, 6'd0,  1'b0, 16'h0000},
    '{ROW_QUERY, 2'd1, 5'd0,  10'd0,    8'd0,   10'd500,  6'd0,  1'b1, 16'hFF00},
    '{ROW_COUNT, REG_COUNT_RED,   5'd0, 10'd0, 8'd0, 10'd0, 6'd63, 1'b0, 16'h0000},
    '{ROW_COUNT, REG_COUNT_RED,   5'd0, 10'd0, 8'd0, 10'd0, 6'd1,  1'b0, 16'h0000},
    '{ROW_QUERY, 2'd0, 5'd0,  10'd0,    8'd0,   10'd700,  6'd0,  1'b0, 16'h0000},
    '{ROW_COUNT, REG_COUNT_BLUE,  5'd0, 10'd0, 8'd0, 10'd0, 6'd32, 1'b0, 16'h0000},
    '{ROW_COUNT, REG_COUNT_BLUE,  5'd0, 10'd0, 8'd0, 10'd0, 6'd2,  1'b0, 16'h0000}
  };

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [REG_IDX_BITS-1:0]  cfg_index;
  logic [COUNT_BITS-1:0]    cfg_data;
  logic                     s_axis_tvalid;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata;   // channel, point_index, point_position,
                                            // point_level, position, zero pad
  logic [0:0]               s_axis_tuser;   // op
  logic                     m_axis_tvalid;
  logic                     m_axis_tready;
  logic [OUT_BITS-1:0]      m_axis_tdata;   // level

  // shadow of the block's state
  entry_t                   point_table  [CHANNELS][MAX_POINTS];
  bit                       point_loaded [CHANNELS][MAX_POINTS];
  logic [COUNT_BITS-1:0]    count_shadow [CHANNELS];

  logic [OUT_BITS-1:0]      expected_levels [$];

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned items_sent = 0, queries_sent = 0, writes_sent = 0;
  int unsigned levels_seen = 0, settings_done = 0;
  int unsigned hold_requests = 0, holds_done = 0;
  bit          steady;

  piecewise_linear_color_ramp uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int unsigned used_count(input logic [CH_BITS-1:0] ch);
    int unsigned n;
    n = 32'(count_shadow[ch]);
    if (n < COUNT_MIN) n = COUNT_MIN;
    if (n > MAX_POINTS) n = MAX_POINTS;
    return n;
  endfunction

  // Q8.8 level of one channel's ramp at x, round half up
  function automatic logic [OUT_BITS-1:0] ramp_level(input logic [CH_BITS-1:0] ch,
                                                     input logic [POSITION_BITS-1:0] x);
    int unsigned       last, j;
    longint unsigned   span, num, dl, dr;
    entry_t            lo, hi;
    if (ch >= CHANNELS) return '0;
    last = used_count(ch) - 1;
    lo = point_table[ch][0];
    hi = point_table[ch][last];
    if (x <= lo.pos) return {lo.lvl, 8'h00};
    if (x >= hi.pos) return {hi.lvl, 8'h00};
    j = 0;
    while (j + 1 < last && point_table[ch][j + 1].pos < x) j++;
    lo = point_table[ch][j];
    hi = point_table[ch][j + 1];
    if (hi.pos <= lo.pos || x < lo.pos || x > hi.pos) return {hi.lvl, 8'h00};
    span = 64'(hi.pos) - 64'(lo.pos);
    dr = 64'(hi.pos) - 64'(x);
    dl = 64'(x) - 64'(lo.pos);
    num = (lo.lvl * dr + hi.lvl * dl) << FRAC_BITS;
    return OUT_BITS'((num + span / 2) / span);
  endfunction

  function automatic bit ramp_ready(input logic [CH_BITS-1:0] ch);
    for (int i = 0; i < used_count(ch); i++)
      if (!point_loaded[ch][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [CH_BITS-1:0] ready_channel();
    int unsigned start;
    start = $urandom_range(CHANNELS - 1, 0);
    for (int k = 0; k < CHANNELS; k++)
      if (ramp_ready(CH_BITS'((start + k) % CHANNELS)))
        return CH_BITS'((start + k) % CHANNELS);
    return 2'd3;
  endfunction

  function automatic logic [POSITION_BITS-1:0] probe_position(input logic [CH_BITS-1:0] ch);
    int          p, off;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 10) return '0;
    if (pick < 20) return '1;
    if (pick < 45) begin
      // land on, or one off, a breakpoint
      p = int'(point_table[ch][$urandom_range(used_count(ch) - 1, 0)].pos);
      off = int'($urandom_range(2, 0));
      p = p + off - 1;
      if (p < 0) p = 0;
      if (p > 1023) p = 1023;
      return p[POSITION_BITS-1:0];
    end
    return POSITION_BITS'($urandom_range(1023, 0));
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_count();
    int unsigned pick;
    pick = $urandom_range(99, 0);
    if (pick < 60) return COUNT_BITS'($urandom_range(6, 2));
    if (pick < 75) return COUNT_BITS'($urandom_range(31, 7));
    if (pick < 85) return COUNT_BITS'(MAX_POINTS);
    if (pick < 90) return COUNT_BITS'(COUNT_MIN);
    if (pick < 95) return COUNT_BITS'($urandom_range(1, 0));
    return COUNT_BITS'($urandom_range(63, 33));
  endfunction

  function automatic void flag_mismatch(input string what, input logic [OUT_BITS-1:0] want,
                                        input logic [OUT_BITS-1:0] got);
    if (fail_count < 10)
      $display("MISMATCH %s: expected level %h, got %h (cycle %0d)", what, want, got,
               cycle_count);
    fail_count++;
  endfunction

  // one input transaction; the prediction is made at the accepting edge
  task automatic send_item(input ramp_item_t it, input logic pinned,
                           input logic [OUT_BITS-1:0] pin);
    in_data_t word;
    while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    word = '0;
    word.channel        = it.ch;
    word.point_index    = it.idx;
    word.point_position = it.ppos;
    word.point_level    = it.plvl;
    word.position       = it.x;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= it.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    if (it.op == OP_WRITE) begin
      writes_sent++;
      if (it.ch < CHANNELS) begin
        point_table[it.ch][it.idx]  = '{pos: it.ppos, lvl: it.plvl};
        point_loaded[it.ch][it.idx] = 1'b1;
      end
    end else begin
      expected_levels.insert(expected_levels.size(),
                             pinned ? pin : ramp_level(it.ch, it.x));
      queries_sent++;
    end
  endtask

  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_count(input logic [REG_IDX_BITS-1:0] sel,
                               input logic [COUNT_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    count_shadow[sel] = val;
    settings_done++;
    @(posedge clk);
  endtask

  // loads every slot in use; mostly rising positions, sometimes scrambled
  task automatic lay_ramp(input logic [CH_BITS-1:0] ch);
    int unsigned n, p;
    bit          scrambled;
    ramp_item_t  it;
    n = used_count(ch);
    scrambled = ($urandom_range(99, 0) < 15);
    p = ($urandom_range(99, 0) < 30) ? 0 : $urandom_range(200, 0);
    for (int i = 0; i < n; i++) begin
      it.op   = OP_WRITE;
      it.ch   = ch;
      it.idx  = PIDX_BITS'(i);
      it.plvl = LEVEL_BITS'($urandom_range(255, 0));
      it.x    = POSITION_BITS'($urandom_range(1023, 0));
      it.ppos = POSITION_BITS'(scrambled ? $urandom_range(1023, 0) : p);
      send_item(it, 1'b0, '0);
      if (i + 1 < n) p = p + $urandom_range((1023 - p) / (n - 1 - i), 0);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d levels still expected", cycle_count,
               expected_levels.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      levels_seen++;
      if (expected_levels.size() == 0)
        flag_mismatch("transaction with nothing expected", 'x, m_axis_tdata);
      else if (expected_levels[0] !== m_axis_tdata)
        flag_mismatch("level", expected_levels.pop_front(), m_axis_tdata);
      else
        void'(expected_levels.pop_front());
    end
  end

  // receiver: random back-pressure plus requested long hold-offs
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < hold_requests) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  initial begin
    dir_row_t    row;
    ramp_item_t  it;
    int unsigned phase, nq, pick;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    steady        = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      count_shadow[c] = COUNT_MIN;
      for (int i = 0; i < MAX_POINTS; i++) begin
        point_table[c][i]  = '0;
        point_loaded[c][i] = 1'b0;
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      row = DIRECTED[i];
      if (row.kind == ROW_COUNT) begin
        settle_block();
        program_count(row.sel, row.cnt);
      end else begin
        it.op   = (row.kind == ROW_QUERY) ? OP_QUERY : OP_WRITE;
        it.ch   = row.sel;
        it.idx  = row.idx;
        it.ppos = row.ppos;
        it.plvl = row.plvl;
        it.x    = row.x;
        send_item(it, row.pinned, row.pin);
      end
    end

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      phase++;
      settle_block();
      for (int r = 0; r < CHANNELS; r++) program_count(COUNT_REGS[r], pick_count());
      steady = (phase == 5);
      for (int c = 0; c < CHANNELS; c++)
        if (!ramp_ready(CH_BITS'(c)) || $urandom_range(1, 0) == 1) lay_ramp(CH_BITS'(c));
      if (phase == 3) hold_requests++;
      nq = $urandom_range(50, 20);
      for (int k = 0; k < nq; k++) begin
        pick    = $urandom_range(99, 0);
        it.idx  = PIDX_BITS'($urandom_range(31, 0));
        it.ppos = POSITION_BITS'($urandom_range(1023, 0));
        it.plvl = LEVEL_BITS'($urandom_range(255, 0));
        it.x    = POSITION_BITS'($urandom_range(1023, 0));
        if (pick < 8) begin
          // stray breakpoint write, any channel and slot
          it.op = OP_WRITE;
          it.ch = CH_BITS'($urandom_range(3, 0));
        end else if (pick < 11) begin
          it.op = OP_QUERY;
          it.ch = 2'd3;
        end else begin
          it.op = OP_QUERY;
          it.ch = ready_channel();
          if (it.ch < CHANNELS) it.x = probe_position(it.ch);
        end
        send_item(it, 1'b0, '0);
      end
    end
    steady = 1'b0;
    settle_block();

    $display("Covered %0d transactions (%0d queries, %0d breakpoint writes), %0d count writes,",
             items_sent, queries_sent, writes_sent, settings_done);
    $display("  %0d levels compared, %0d long output hold-offs, %0d mismatches.",
             levels_seen, holds_done, fail_count);
    if (fail_count == 0 && expected_levels.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
